// ===== rtl/hlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hlp_pkg
// Types and codes shared by the hash table blocks.
// ----------------------------------------------------------------------------
package hlp_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int PHONE_W  = 34;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int CFG_W    = 7;
    // Sum of at most eight bytes.
    localparam int SUM_W    = 11;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [PHONE_W-1:0]  t_phone;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [SLOT_W-1:0]   t_slot;

    localparam t_mode MODE_DIRECT  = 2'd0;
    localparam t_mode MODE_PROBE   = 2'd1;
    localparam t_mode MODE_REPLACE = 2'd2;
    localparam t_mode MODE_SEARCH  = 2'd3;

    localparam t_status ST_STORED    = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_FOUND     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/hlp_in_if.sv =====
// ----------------------------------------------------------------------------
// hlp_in_if
// Request channel: mode, name key and phone number.
// ----------------------------------------------------------------------------
interface hlp_in_if;
    logic             valid;
    logic             ready;
    hlp_pkg::t_mode   mode;
    hlp_pkg::t_key    name_key;
    hlp_pkg::t_phone  phone_number;

    modport source (output valid, mode, name_key, phone_number, input ready);
    modport sink   (input valid, mode, name_key, phone_number, output ready);
endinterface

// ===== rtl/hlp_out_if.sv =====
// ----------------------------------------------------------------------------
// hlp_out_if
// Result channel: status and slot.
// ----------------------------------------------------------------------------
interface hlp_out_if;
    logic             valid;
    logic             ready;
    hlp_pkg::t_status status;
    hlp_pkg::t_slot   slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

// ===== rtl/hlp_ram.sv =====
// ----------------------------------------------------------------------------
// hlp_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/hlp_hash.sv =====
// ----------------------------------------------------------------------------
// hlp_hash
// Home slot unit: byte sum of the key, reduced modulo the table size by a
// restoring remainder that takes one bit per cycle.
// ----------------------------------------------------------------------------
module hlp_hash #(
    parameter int DEPTH     = 64,
    parameter int KEY_CHARS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  hlp_pkg::t_key              i_key,
    input  logic [$clog2(DEPTH):0]     i_size,
    output logic                       o_done,
    output logic [$clog2(DEPTH)-1:0]   o_home
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = AW + 1;
    localparam int CW = $clog2(hlp_pkg::SUM_W + 1);

    logic [hlp_pkg::SUM_W-1:0] sum;
    logic [hlp_pkg::SUM_W-1:0] r_div, n_div;
    logic [AW-1:0]             r_rem, n_rem;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_done, n_done;
    logic [NW-1:0]             trial;

    always_comb begin
        sum = '0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            sum = sum + hlp_pkg::SUM_W'(i_key[8*i +: 8]);
        end
    end

    always_comb begin
        n_div  = r_div;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        trial  = {r_rem, r_div[hlp_pkg::SUM_W-1]};
        if (i_start) begin
            n_div = sum;
            n_rem = '0;
            n_cnt = CW'(hlp_pkg::SUM_W);
        end else if (r_cnt != '0) begin
            n_div = {r_div[hlp_pkg::SUM_W-2:0], 1'b0};
            if (trial >= i_size) begin
                n_rem = AW'(trial - i_size);
            end else begin
                n_rem = AW'(trial);
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_home = r_rem;
endmodule

// ===== rtl/hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// hash_table_linear_probe
// Open-addressing name/phone hash table with linear probing.
// ----------------------------------------------------------------------------
// A request transaction on i_in carries a mode (direct insert, probing insert,
// insert with replacement, search), a packed name key and a phone number.
// Each request gives exactly one result transaction on o_out with a status
// and a slot. i_cfg_we/i_cfg_data set the number of slots in use; write it
// only while no request is in flight.
// One request is worked at a time. Every home slot is reckoned in the shared
// remainder unit; every probed slot is read through the table RAM read port
// and then checked. Each eviction of insert with replacement takes a slot
// read, the occupant's home, the write and the evicted key's home.
// After reset the table RAMs are swept to zero, one slot per cycle, and
// no request is taken meanwhile. A result waits in an output register while
// the receiver stalls; the next request may be taken then, but its result
// holds until the register is free.
// ----------------------------------------------------------------------------
module hash_table_linear_probe #(
    parameter int DEPTH     = 64,
    parameter int KEY_CHARS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hlp_in_if.sink                     i_in,
    hlp_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [hlp_pkg::CFG_W-1:0]  i_cfg_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = AW + 1;
    localparam hlp_pkg::t_key KEY_MASK = {hlp_pkg::KEY_W{1'b1}} >> (64 - 8 * KEY_CHARS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PCK   = 4'd4;
    localparam logic [3:0] S_ORD   = 4'd5;
    localparam logic [3:0] S_OCK   = 4'd6;
    localparam logic [3:0] S_EVICT = 4'd7;
    localparam logic [3:0] S_WRITE = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic [1:0] H_MAIN  = 2'd0;
    localparam logic [1:0] H_OCC   = 2'd1;
    localparam logic [1:0] H_CHAIN = 2'd2;

    localparam logic [1:0] P_INS  = 2'd0;
    localparam logic [1:0] P_PRE  = 2'd1;
    localparam logic [1:0] P_EV   = 2'd2;
    localparam logic [1:0] P_SRCH = 2'd3;

    logic [3:0]               r_state, n_state;
    logic [1:0]               r_hctx, n_hctx;
    logic [1:0]               r_pkind, n_pkind;
    hlp_pkg::t_mode           r_mode, n_mode;
    hlp_pkg::t_key            r_ck, n_ck;
    hlp_pkg::t_phone          r_cp, n_cp;
    hlp_pkg::t_key            r_occ, n_occ;
    hlp_pkg::t_phone          r_occp, n_occp;
    logic [AW-1:0]            r_addr, n_addr;
    logic [AW-1:0]            r_home, n_home;
    logic [AW-1:0]            r_slot, n_slot;
    logic [NW-1:0]            r_cnt, n_cnt;
    logic                     r_first, n_first;
    hlp_pkg::t_status         r_status, n_status;
    logic [hlp_pkg::CFG_W-1:0] r_tsize;
    logic                     r_ovalid, n_ovalid;
    hlp_pkg::t_status         r_ostatus, n_ostatus;
    hlp_pkg::t_slot           r_oslot, n_oslot;

    logic [NW-1:0]            size;
    logic                     h_start, h_done;
    hlp_pkg::t_key            h_key;
    logic [AW-1:0]            h_home;
    logic                     we;
    hlp_pkg::t_key            key_wdata, key_rdata;
    hlp_pkg::t_phone          phone_wdata, phone_rdata;
    logic                     hit;
    logic [AW-1:0]            addr_next;

    always_comb begin
        if (r_tsize == '0) begin
            size = NW'(1);
        end else if (int'(r_tsize) > DEPTH) begin
            size = NW'(DEPTH);
        end else begin
            size = NW'(r_tsize);
        end
    end

    hlp_hash #(.DEPTH(DEPTH), .KEY_CHARS(KEY_CHARS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_key   (h_key),
        .i_size  (size),
        .o_done  (h_done),
        .o_home  (h_home)
    );

    hlp_ram #(.WIDTH(hlp_pkg::KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (r_addr),
        .i_wdata (key_wdata),
        .o_rdata (key_rdata)
    );

    hlp_ram #(.WIDTH(hlp_pkg::PHONE_W), .DEPTH(DEPTH)) u_phone_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (r_addr),
        .i_wdata (phone_wdata),
        .o_rdata (phone_rdata)
    );

    assign we          = (r_state == S_CLEAR) || (r_state == S_EVICT) || (r_state == S_WRITE);
    assign key_wdata   = (r_state == S_CLEAR) ? '0 : r_ck;
    assign phone_wdata = (r_state == S_CLEAR) ? '0 : r_cp;
    assign addr_next   = ((NW'(r_addr) + 1'b1) == size) ? '0 : r_addr + 1'b1;
    assign hit         = (r_pkind == P_SRCH) ? (key_rdata == r_ck) : (key_rdata == '0);

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_hctx    = r_hctx;
        n_pkind   = r_pkind;
        n_mode    = r_mode;
        n_ck      = r_ck;
        n_cp      = r_cp;
        n_occ     = r_occ;
        n_occp    = r_occp;
        n_addr    = r_addr;
        n_home    = r_home;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_oslot   = r_oslot;
        h_start   = 1'b0;
        h_key     = r_ck;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode  = i_in.mode;
                    n_ck    = i_in.name_key & KEY_MASK;
                    n_cp    = i_in.phone_number;
                    n_first = 1'b1;
                    n_slot  = '0;
                    n_hctx  = H_MAIN;
                    h_key   = i_in.name_key & KEY_MASK;
                    h_start = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (h_done) begin
                    case (r_hctx)
                        H_MAIN: begin
                            n_home = h_home;
                            n_addr = h_home;
                            n_cnt  = '0;
                            case (r_mode)
                                hlp_pkg::MODE_DIRECT: n_state = S_WRITE;
                                hlp_pkg::MODE_PROBE: begin
                                    n_pkind = P_INS;
                                    n_state = S_PRD;
                                end
                                hlp_pkg::MODE_REPLACE: begin
                                    n_pkind = P_PRE;
                                    n_state = S_PRD;
                                end
                                default: begin
                                    if (r_ck == '0) begin
                                        n_status = hlp_pkg::ST_NOT_FOUND;
                                        n_slot   = '0;
                                        n_state  = S_FIN;
                                    end else begin
                                        n_pkind = P_SRCH;
                                        n_state = S_PRD;
                                    end
                                end
                            endcase
                        end
                        H_OCC: begin
                            // An occupant at its own home stays; the new key
                            // goes to the next empty slot instead.
                            if (h_home == r_addr) begin
                                n_pkind = P_EV;
                                n_cnt   = '0;
                                n_state = S_PRD;
                            end else begin
                                n_state = S_EVICT;
                            end
                        end
                        default: begin
                            n_addr  = h_home;
                            n_state = S_ORD;
                        end
                    endcase
                end
            end
            S_PRD: n_state = S_PCK;
            S_PCK: begin
                if (hit) begin
                    case (r_pkind)
                        P_PRE: begin
                            n_addr  = r_home;
                            n_state = S_ORD;
                        end
                        P_SRCH: begin
                            n_status = hlp_pkg::ST_FOUND;
                            n_slot   = r_addr;
                            n_state  = S_FIN;
                        end
                        default: n_state = S_WRITE;
                    endcase
                end else if (r_cnt == size - 1'b1) begin
                    n_status = (r_pkind == P_SRCH) ? hlp_pkg::ST_NOT_FOUND : hlp_pkg::ST_FULL;
                    n_slot   = '0;
                    n_state  = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_addr  = addr_next;
                    n_state = S_PRD;
                end
            end
            S_ORD: n_state = S_OCK;
            S_OCK: begin
                if (key_rdata == '0) begin
                    n_state = S_WRITE;
                end else begin
                    n_occ   = key_rdata;
                    n_occp  = phone_rdata;
                    n_hctx  = H_OCC;
                    h_key   = key_rdata;
                    h_start = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_EVICT: begin
                // The displaced entry becomes the key carried down the chain.
                if (r_first) begin
                    n_slot = r_addr;
                end
                n_first = 1'b0;
                n_ck    = r_occ;
                n_cp    = r_occp;
                n_hctx  = H_CHAIN;
                h_key   = r_occ;
                h_start = 1'b1;
                n_state = S_HASH;
            end
            S_WRITE: begin
                if (r_first) begin
                    n_slot = r_addr;
                end
                n_first  = 1'b0;
                n_status = hlp_pkg::ST_STORED;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oslot   = hlp_pkg::SLOT_W'(r_slot);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            r_tsize  <= hlp_pkg::CFG_W'(64);
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_tsize <= i_cfg_data;
            end
        end
        r_hctx    <= n_hctx;
        r_pkind   <= n_pkind;
        r_mode    <= n_mode;
        r_ck      <= n_ck;
        r_cp      <= n_cp;
        r_occ     <= n_occ;
        r_occp    <= n_occp;
        r_home    <= n_home;
        r_slot    <= n_slot;
        r_cnt     <= n_cnt;
        r_first   <= n_first;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_oslot   <= n_oslot;
    end

    assign o_out.valid  = r_ovalid;
    assign o_out.status = r_ostatus;
    assign o_out.slot   = r_oslot;

    a_hash_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_done |-> (r_state == S_HASH))
        else $error("home slot finished outside the wait state");

    a_probe_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCK) |-> (r_cnt < size))
        else $error("probe ran past the table size");

    a_probe_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRD) |-> (NW'(r_addr) < size))
        else $error("probe address beyond the slots in use");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state != S_IDLE) && (r_state != S_FIN))
        else $error("table written while no work is pending");
endmodule
